// ===== sv/tgd_pkg.sv =====
// Shared types, register indexes and codes for the touch rotate and gesture detector.
`default_nettype none

package tgd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_ROTATION     = 3'd0;
  localparam logic [2:0] CFG_PANEL_WIDTH  = 3'd1;
  localparam logic [2:0] CFG_PANEL_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_SWIPE_THRESH = 3'd3;
  localparam logic [2:0] CFG_TAP_WINDOW   = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Display rotations
  localparam logic [1:0] ROT_PORTRAIT       = 2'd0;
  localparam logic [1:0] ROT_LANDSCAPE      = 2'd1;
  localparam logic [1:0] ROT_PORTRAIT_INV   = 2'd2;
  localparam logic [1:0] ROT_LANDSCAPE_INV  = 2'd3;

  // Swipe codes
  localparam logic [1:0] SWIPE_NONE  = 2'd0;
  localparam logic [1:0] SWIPE_RIGHT = 2'd1;
  localparam logic [1:0] SWIPE_LEFT  = 2'd2;

  // Touch status codes that mean touched
  localparam logic [7:0] COUNT_ONE = 8'd1;
  localparam logic [7:0] COUNT_TWO = 8'd2;

  // Reset values of the registers
  localparam logic [1:0]  RST_ROTATION     = ROT_PORTRAIT;
  localparam logic [12:0] RST_PANEL_WIDTH  = 13'd240;
  localparam logic [12:0] RST_PANEL_HEIGHT = 13'd320;
  localparam logic [11:0] RST_SWIPE_THRESH = 12'd60;
  localparam logic [15:0] RST_TAP_WINDOW   = 16'd350;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  rotation;
    logic [12:0] panel_width;
    logic [12:0] panel_height;
    logic [11:0] swipe_threshold;
    logic [15:0] double_tap_window;
  } cfg_t;

  // One classified poll
  typedef struct packed {
    logic        touched;
    logic [13:0] x;
    logic [13:0] y;
    logic [31:0] now_ms;
  } cls_t;

endpackage

`default_nettype wire

// ===== sv/tgd_front.sv =====
// Front stage: accept a poll, decide touched and map the point to the display rotation.
`default_nettype none

module tgd_front (
  input  logic                clk,
  input  logic                rst,
  input  tgd_pkg::cfg_t       cfg,
  input  logic                poll_valid,
  output logic                poll_stall,
  input  logic [7:0]          point_count,
  input  logic [7:0]          x_high_byte,
  input  logic [7:0]          x_low_byte,
  input  logic [7:0]          y_high_byte,
  input  logic [7:0]          y_low_byte,
  input  logic [31:0]         now_ms,
  output logic                cls_valid,
  output tgd_pkg::cls_t       cls,
  input  logic                cls_take
);
  import tgd_pkg::*;

  logic [11:0] tx;
  logic [11:0] ty;
  logic [13:0] pw_m1;
  logic [13:0] ph_m1;
  logic [13:0] nx;
  logic [13:0] ny;
  logic        load;

  assign tx    = {x_high_byte[3:0], x_low_byte};
  assign ty    = {y_high_byte[3:0], y_low_byte};
  assign pw_m1 = {1'b0, cfg.panel_width} - 14'd1;
  assign ph_m1 = {1'b0, cfg.panel_height} - 14'd1;

  // Mapping is modulo 2^14, which is the wrap the point fields carry
  always_comb begin
    unique case (cfg.rotation)
      ROT_LANDSCAPE: begin
        nx = {2'b00, ty};
        ny = pw_m1 - {2'b00, tx};
      end
      ROT_PORTRAIT_INV: begin
        nx = pw_m1 - {2'b00, tx};
        ny = ph_m1 - {2'b00, ty};
      end
      ROT_LANDSCAPE_INV: begin
        nx = ph_m1 - {2'b00, ty};
        ny = {2'b00, tx};
      end
      default: begin
        nx = {2'b00, tx};
        ny = {2'b00, ty};
      end
    endcase
  end

  assign poll_stall = cls_valid && !cls_take;
  assign load       = poll_valid && !poll_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (load) begin
      cls_valid <= 1'b1;
    end else if (cls_take) begin
      cls_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cls.touched <= (point_count == COUNT_ONE) || (point_count == COUNT_TWO);
      cls.x       <= nx;
      cls.y       <= ny;
      cls.now_ms  <= now_ms;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tgd_queue.sv =====
// Short queue of classified polls between the front and back stages.
`default_nettype none

module tgd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_take,
  input  tgd_pkg::cls_t  push_data,
  output logic           pop_valid,
  input  logic           pop_take,
  output tgd_pkg::cls_t  pop_data
);
  import tgd_pkg::*;

  cls_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  assign push_take = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign push      = push_valid && push_take;
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_take;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tgd_back.sv =====
// Back stage: gesture state, swipe and double-tap decisions, and the result register.
`default_nettype none

module tgd_back (
  input  logic               clk,
  input  logic               rst,
  input  tgd_pkg::cfg_t      cfg,
  input  logic               cls_valid,
  output logic               cls_take,
  input  tgd_pkg::cls_t      cls,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               pressed,
  output logic signed [13:0] point_x,
  output logic signed [13:0] point_y,
  output logic [1:0]         swipe_event,
  output logic               double_tap
);
  import tgd_pkg::*;

  logic signed [13:0] last_x;
  logic signed [13:0] last_y;
  logic signed [13:0] start_x;
  logic signed [13:0] start_y;
  logic               was_pressed;
  logic               press_active;
  logic               tap_armed;
  logic [31:0]        arm_time;

  logic signed [13:0] last_x_next;
  logic signed [13:0] last_y_next;
  logic signed [14:0] dx;
  logic signed [14:0] dy;
  logic [14:0]        adx;
  logic [14:0]        ady;
  logic [31:0]        elapsed;
  logic               release_ev;
  logic               is_swipe;
  logic               tap_fire;
  logic               step;

  assign step     = cls_valid && cls_take;
  assign cls_take = !result_valid || !result_stall;

  assign last_x_next = cls.touched ? $signed(cls.x) : last_x;
  assign last_y_next = cls.touched ? $signed(cls.y) : last_y;

  // Travel since the press began; only read on a release, when last is unchanged
  assign dx  = {last_x[13], last_x} - {start_x[13], start_x};
  assign dy  = {last_y[13], last_y} - {start_y[13], start_y};
  assign adx = dx[14] ? 15'(-dx) : dx;
  assign ady = dy[14] ? 15'(-dy) : dy;

  assign release_ev = was_pressed && !cls.touched;
  assign is_swipe   = release_ev && (adx >= {3'b000, cfg.swipe_threshold}) &&
                      ({1'b0, adx} > {ady, 1'b0});
  assign elapsed    = cls.now_ms - arm_time;
  assign tap_fire   = release_ev && !is_swipe && tap_armed &&
                      (elapsed <= {16'h0000, cfg.double_tap_window});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= '0;
      last_y       <= '0;
      start_x      <= '0;
      start_y      <= '0;
      was_pressed  <= 1'b0;
      press_active <= 1'b0;
      tap_armed    <= 1'b0;
      arm_time     <= '0;
    end else if (step) begin
      last_x <= last_x_next;
      last_y <= last_y_next;
      if (is_swipe) begin
        tap_armed    <= 1'b0;
        was_pressed  <= 1'b0;
        press_active <= 1'b0;
      end else begin
        if (release_ev) begin
          if (tap_fire) begin
            tap_armed <= 1'b0;
          end else begin
            tap_armed <= 1'b1;
            arm_time  <= cls.now_ms;
          end
        end
        was_pressed <= cls.touched;
        if (cls.touched) begin
          if (!press_active) begin
            press_active <= 1'b1;
            start_x      <= last_x_next;
            start_y      <= last_y_next;
          end
        end else begin
          press_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pressed     <= cls.touched;
      point_x     <= last_x_next;
      point_y     <= last_y_next;
      swipe_event <= !is_swipe ? SWIPE_NONE : (dx > 0) ? SWIPE_RIGHT : SWIPE_LEFT;
      double_tap  <= tap_fire;
    end
  end

`ifndef SYNTHESIS
  a_swipe_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && (swipe_event != SWIPE_NONE) |-> !double_tap && !pressed)
    else $error("swipe result carries a press or a double tap");

  a_tap_disarms: assert property (@(posedge clk) disable iff (rst)
    step && tap_fire |=> !tap_armed)
    else $error("double tap left the arm set");

  a_press_tracks: assert property (@(posedge clk) disable iff (rst)
    press_active == was_pressed)
    else $error("press flags disagree");

  a_swipe_code: assert property (@(posedge clk) disable iff (rst)
    step && is_swipe |=> swipe_event == SWIPE_RIGHT || swipe_event == SWIPE_LEFT)
    else $error("swipe release gave no direction");
`endif

endmodule

`default_nettype wire

// ===== sv/touch_rotate_and_gesture_detect.sv =====
// Top level of the touch rotate and gesture detector: configuration registers and the stages.
`default_nettype none

// Takes one touch poll per clock while not stalled and gives one result per poll, in order.
// A poll is accepted when poll_valid is high and poll_stall low; a result is
// taken when result_valid is high and result_stall low. Throughput is one
// poll per cycle while neither side stalls; a poll passes through the front
// register, four-entry queue and result register. The gesture state lives in
// the back stage and is updated in the same cycle as its result is loaded,
// so consecutive polls never wait on each other. Write configuration
// through cfg_write/cfg_index/cfg_data only while no poll is in flight.
// Coordinates are mapped to the display rotation without clamping and wrap
// to 14 bits; swipes are reported on release when horizontal travel reaches
// the threshold and exceeds twice the vertical travel, otherwise the release
// arms or fires a double tap (timestamp difference taken modulo 2^32).

module touch_rotate_and_gesture_detect (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tgd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tgd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             poll_valid,
  output logic                             poll_stall,
  input  logic [7:0]                       point_count,
  input  logic [7:0]                       x_high_byte,
  input  logic [7:0]                       x_low_byte,
  input  logic [7:0]                       y_high_byte,
  input  logic [7:0]                       y_low_byte,
  input  logic [31:0]                      now_ms,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             pressed,
  output logic signed [13:0]               point_x,
  output logic signed [13:0]               point_y,
  output logic [1:0]                       swipe_event,
  output logic                             double_tap
);
  import tgd_pkg::*;

  cfg_t cfg;
  logic front_valid;
  logic front_take;
  cls_t front_cls;
  logic queue_valid;
  logic queue_take;
  cls_t queue_cls;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation          <= RST_ROTATION;
      cfg.panel_width       <= RST_PANEL_WIDTH;
      cfg.panel_height      <= RST_PANEL_HEIGHT;
      cfg.swipe_threshold   <= RST_SWIPE_THRESH;
      cfg.double_tap_window <= RST_TAP_WINDOW;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROTATION:     cfg.rotation          <= cfg_data[1:0];
        CFG_PANEL_WIDTH:  cfg.panel_width       <= cfg_data[12:0];
        CFG_PANEL_HEIGHT: cfg.panel_height      <= cfg_data[12:0];
        CFG_SWIPE_THRESH: cfg.swipe_threshold   <= cfg_data[11:0];
        CFG_TAP_WINDOW:   cfg.double_tap_window <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front: classify the poll and map it to the display rotation
  tgd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .poll_valid  (poll_valid),
    .poll_stall  (poll_stall),
    .point_count (point_count),
    .x_high_byte (x_high_byte),
    .x_low_byte  (x_low_byte),
    .y_high_byte (y_high_byte),
    .y_low_byte  (y_low_byte),
    .now_ms      (now_ms),
    .cls_valid   (front_valid),
    .cls         (front_cls),
    .cls_take    (front_take)
  );

  // Queue: decouple the front from result back-pressure
  tgd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_take  (front_take),
    .push_data  (front_cls),
    .pop_valid  (queue_valid),
    .pop_take   (queue_take),
    .pop_data   (queue_cls)
  );

  // Back: advance gesture state and register the result
  tgd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cls_valid    (queue_valid),
    .cls_take     (queue_take),
    .cls          (queue_cls),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pressed      (pressed),
    .point_x      (point_x),
    .point_y      (point_y),
    .swipe_event  (swipe_event),
    .double_tap   (double_tap)
  );

endmodule

`default_nettype wire

// ===== test/tb_touch_rotate_and_gesture_detect.sv =====
// Testbench for the touch rotate and gesture detector: directed table, then random gestures.
`timescale 1ns / 1ps

module tb_touch_rotate_and_gesture_detect;
  import tgd_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int STALL_LIMIT = 5000;   // cycles with no item moving on either side
  localparam int DRAIN_CYCLES = 8;
  localparam int SEGMENTS = 6;
  localparam int POLLS_PER_SEGMENT = 305;
  localparam int MAX_REPORTS = 10;

  // Idling schemes: sender light and receiver heavy, the reverse, then none
  localparam int IDLE_SEND_LIGHT = 0;
  localparam int IDLE_SEND_HEAVY = 1;
  localparam int IDLE_NONE       = 2;

  // One poll of the touch controller
  typedef struct {
    logic [7:0]  cnt;
    logic [7:0]  xh;
    logic [7:0]  xl;
    logic [7:0]  yh;
    logic [7:0]  yl;
    logic [31:0] stamp;
  } poll_t;

  // One reported gesture result
  typedef struct {
    logic               pressed;
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic [1:0]         swipe;
    logic               dtap;
  } gesture_t;

  // A row of the directed table: a register write or a poll, with an
  // optional hand-typed expectation
  typedef struct {
    bit                      is_write;
    logic [CFG_INDEX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    poll_t                   p;
    bit                      typed;
    gesture_t                e;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROTATION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic poll_valid = 1'b0;
  logic poll_stall;
  logic [7:0] point_count = '0;
  logic [7:0] x_high_byte = '0;
  logic [7:0] x_low_byte = '0;
  logic [7:0] y_high_byte = '0;
  logic [7:0] y_low_byte = '0;
  logic [31:0] now_ms = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic pressed;
  logic signed [13:0] point_x;
  logic signed [13:0] point_y;
  logic [1:0] swipe_event;
  logic double_tap;

  touch_rotate_and_gesture_detect u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .point_count  (point_count),
    .x_high_byte  (x_high_byte),
    .x_low_byte   (x_low_byte),
    .y_high_byte  (y_high_byte),
    .y_low_byte   (y_low_byte),
    .now_ms       (now_ms),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pressed      (pressed),
    .point_x      (point_x),
    .point_y      (point_y),
    .swipe_event  (swipe_event),
    .double_tap   (double_tap)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor copy of the registers
  logic [1:0]  cf_rot;
  logic [12:0] cf_width;
  logic [12:0] cf_height;
  logic [11:0] cf_thresh;
  logic [15:0] cf_window;

  // Predictor copy of the gesture state
  logic signed [13:0] cur_x, cur_y, org_x, org_y;
  bit                 held, in_press, armed;
  logic [31:0]        armed_at;

  gesture_t gesture_q[$];      // expected results, oldest first
  row_t     dir_rows[$];
  int       idle_mode = IDLE_SEND_LIGHT;
  int       errors = 0;
  int       polls_sent = 0;
  int       quiet_cycles = 0;
  logic [31:0] clock_ms = '0;  // running millisecond stamp of the random polls

  // Work out the result of one accepted poll and advance the gesture state
  function automatic gesture_t predict_gesture(poll_t p);
    gesture_t   r;
    bit         touched;
    int         tx, ty, pw, ph, nx, ny, dx, dy, adx, ady, sa, sb;
    logic [31:0] gap;
    touched = (p.cnt == COUNT_ONE) || (p.cnt == COUNT_TWO);
    r.swipe = SWIPE_NONE;
    r.dtap = 1'b0;
    if (touched) begin
      tx = {p.xh[3:0], p.xl};
      ty = {p.yh[3:0], p.yl};
      pw = cf_width;
      ph = cf_height;
      case (cf_rot)
        ROT_LANDSCAPE: begin
          nx = ty;
          ny = pw - 1 - tx;
        end
        ROT_PORTRAIT_INV: begin
          nx = pw - 1 - tx;
          ny = ph - 1 - ty;
        end
        ROT_LANDSCAPE_INV: begin
          nx = ph - 1 - ty;
          ny = tx;
        end
        default: begin
          nx = tx;
          ny = ty;
        end
      endcase
      cur_x = nx[13:0];
      cur_y = ny[13:0];
    end
    if (held && !touched) begin
      sa = cur_x;
      sb = org_x;
      dx = sa - sb;
      sa = cur_y;
      sb = org_y;
      dy = sa - sb;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (adx >= int'(cf_thresh) && adx > 2 * ady) begin
        // swipe release drops the tap arm and ends the press outright
        armed = 1'b0;
        held = 1'b0;
        in_press = 1'b0;
        r.pressed = 1'b0;
        r.x = cur_x;
        r.y = cur_y;
        r.swipe = (dx > 0) ? SWIPE_RIGHT : SWIPE_LEFT;
        return r;
      end
      gap = p.stamp - armed_at;
      if (armed && gap <= {16'd0, cf_window}) begin
        armed = 1'b0;
        r.dtap = 1'b1;
      end else begin
        armed = 1'b1;
        armed_at = p.stamp;
      end
    end
    held = touched;
    if (touched) begin
      if (!in_press) begin
        in_press = 1'b1;
        org_x = cur_x;
        org_y = cur_y;
      end
    end else begin
      in_press = 1'b0;
    end
    r.pressed = touched;
    r.x = cur_x;
    r.y = cur_y;
    return r;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SEND_LIGHT: return $urandom_range(0, 99) < 27;
      IDLE_SEND_HEAVY: return $urandom_range(0, 99) < 85;
      default:         return 1'b0;
    endcase
  endfunction

  // Receiver: stall at random, driven at the falling edge
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_SEND_LIGHT: result_stall = $urandom_range(0, 99) < 85;
      IDLE_SEND_HEAVY: result_stall = $urandom_range(0, 99) < 27;
      default:         result_stall = 1'b0;
    endcase
  end

  // Offer one poll, holding it until taken; predict at the accepting edge
  task automatic send_poll(input poll_t p, input bit typed, input gesture_t e);
    gesture_t want;
    @(negedge clk);
    while (sender_idles()) begin
      poll_valid = 1'b0;
      point_count = 8'($urandom);
      x_low_byte = 8'($urandom);
      @(negedge clk);
    end
    poll_valid = 1'b1;
    point_count = p.cnt;
    x_high_byte = p.xh;
    x_low_byte = p.xl;
    y_high_byte = p.yh;
    y_low_byte = p.yl;
    now_ms = p.stamp;
    do @(posedge clk); while (poll_stall);
    want = predict_gesture(p);
    gesture_q.push_back(typed ? e : want);
    polls_sent++;
  endtask

  // Write one register once the block has drained
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    poll_valid = 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_ROTATION:     cf_rot = val[1:0];
      CFG_PANEL_WIDTH:  cf_width = val[12:0];
      CFG_PANEL_HEIGHT: cf_height = val[12:0];
      CFG_SWIPE_THRESH: cf_thresh = val[11:0];
      CFG_TAP_WINDOW:   cf_window = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [1:0] rot, input int w, input int h, input int thr,
                           input int win);
    write_reg(CFG_ROTATION, CFG_DATA_W'(rot));
    write_reg(CFG_PANEL_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_PANEL_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_SWIPE_THRESH, CFG_DATA_W'(thr));
    write_reg(CFG_TAP_WINDOW, CFG_DATA_W'(win));
  endtask

  function automatic poll_t make_poll(input logic [7:0] cnt, input logic [11:0] x,
                                      input logic [11:0] y, input logic [31:0] stamp);
    poll_t p;
    // upper nibbles of the high bytes carry noise the block must ignore
    p.cnt = cnt;
    p.xh = {4'($urandom), x[11:8]};
    p.xl = x[7:0];
    p.yh = {4'($urandom), y[11:8]};
    p.yl = y[7:0];
    p.stamp = stamp;
    return p;
  endfunction

  function automatic void add_poll(input logic [7:0] cnt, input logic [11:0] x,
                                   input logic [11:0] y, input logic [31:0] stamp);
    row_t r;
    r = '{default: '0};
    r.p = make_poll(cnt, x, y, stamp);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_typed(input poll_t p, input logic pr, input int x, input int y);
    row_t r;
    r = '{default: '0};
    r.p = p;
    r.typed = 1'b1;
    r.e.pressed = pr;
    r.e.x = 14'(x);
    r.e.y = 14'(y);
    r.e.swipe = SWIPE_NONE;
    r.e.dtap = 1'b0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx, input int val);
    row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = CFG_DATA_W'(val);
    dir_rows.push_back(r);
  endfunction

  // One random gesture: a press with random travel and a release, or noise
  task automatic run_gesture();
    poll_t    p;
    gesture_t none;
    int       kind, n, sx, sy, tmp;
    logic [11:0] gx, gy;
    none = '{default: '0};
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      // noise: any status byte, any coordinates, odd stamps
      p.cnt = 8'($urandom);
      p.xh = 8'($urandom);
      p.xl = 8'($urandom);
      p.yh = 8'($urandom);
      p.yl = 8'($urandom);
      if (kind == 0) clock_ms = $urandom;
      else clock_ms += 32'($urandom_range(0, 500));
      p.stamp = clock_ms;
      send_poll(p, 1'b0, none);
      return;
    end
    n = $urandom_range(1, 6);
    gx = 12'($urandom);
    gy = 12'($urandom);
    if (kind < 11) begin
      sx = $urandom_range(0, 400) - 200;
      sy = $urandom_range(0, 60) - 30;
    end else begin
      sx = $urandom_range(0, 6) - 3;
      sy = $urandom_range(0, 6) - 3;
    end
    // rotations swap the axes, so travel along either raw axis
    if ($urandom_range(0, 1)) begin
      tmp = sx;
      sx = sy;
      sy = tmp;
    end
    for (int i = 0; i < n; i++) begin
      clock_ms += 32'($urandom_range(1, 40));
      p = make_poll(8'($urandom_range(1, 2)), gx, gy, clock_ms);
      send_poll(p, 1'b0, none);
      gx = gx + 12'(sx);
      gy = gy + 12'(sy);
    end
    // now and then leave the press open so the next gesture runs into it
    if (kind != 19) begin
      clock_ms += 32'($urandom_range(1, 40));
      p = make_poll(($urandom_range(0, 3) == 0) ? 8'($urandom_range(3, 255)) : 8'd0,
                    12'($urandom), 12'($urandom), clock_ms);
      send_poll(p, 1'b0, none);
    end
    if ($urandom_range(0, 1)) clock_ms += 32'($urandom_range(0, int'(cf_window) + 40));
    else clock_ms += 32'($urandom_range(0, 3000));
  endtask

  // Compare every taken result with the oldest expectation
  always @(posedge clk) begin
    gesture_t want;
    if (!rst && result_valid && !result_stall) begin
      if (gesture_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected: p=%0b x=%0d y=%0d s=%0d d=%0b",
                   $realtime, pressed, point_x, point_y, swipe_event, double_tap);
      end else begin
        want = gesture_q.pop_front();
        if (pressed !== want.pressed || point_x !== want.x || point_y !== want.y ||
            swipe_event !== want.swipe || double_tap !== want.dtap) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: mismatch: want p=%0b x=%0d y=%0d s=%0d d=%0b,",
                     $realtime, want.pressed, want.x, want.y, want.swipe, want.dtap,
                     " got p=%0b x=%0d y=%0d s=%0d d=%0b",
                     pressed, point_x, point_y, swipe_event, double_tap);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((poll_valid && !poll_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("tb_touch_rotate_and_gesture_detect: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Hold the predictor at its reset state
    cf_rot = RST_ROTATION;
    cf_width = RST_PANEL_WIDTH;
    cf_height = RST_PANEL_HEIGHT;
    cf_thresh = RST_SWIPE_THRESH;
    cf_window = RST_TAP_WINDOW;
    cur_x = '0;
    cur_y = '0;
    org_x = '0;
    org_y = '0;
    held = 1'b0;
    in_press = 1'b0;
    armed = 1'b0;
    armed_at = '0;

    // Directed table, reset registers first
    // release with no press after reset: all events clear, point still zero
    add_typed(make_poll(8'd0, 12'hFFF, 12'hFFF, 32'd0), 1'b0, 0, 0);
    // coordinate extremes in portrait come straight through
    add_typed(make_poll(COUNT_ONE, 12'hFFF, 12'h000, 32'd10), 1'b1, 4095, 0);
    add_typed(make_poll(COUNT_TWO, 12'h000, 12'hFFF, 32'd20), 1'b1, 0, 4095);
    // diagonal release: no swipe, arms a tap; second tap fires it
    add_poll(8'd3, 12'd0, 12'd0, 32'd30);
    add_poll(COUNT_ONE, 12'd100, 12'd100, 32'd100);
    add_poll(8'd0, 12'd0, 12'd0, 32'd150);
    // swipe right, released with the top status code
    add_poll(COUNT_ONE, 12'd100, 12'd200, 32'd200);
    add_poll(COUNT_ONE, 12'd300, 12'd210, 32'd220);
    add_poll(8'd255, 12'd0, 12'd0, 32'd240);
    // swipe left
    add_poll(COUNT_TWO, 12'd900, 12'd50, 32'd300);
    add_poll(COUNT_ONE, 12'd500, 12'd60, 32'd320);
    add_poll(8'd0, 12'd0, 12'd0, 32'd340);
    // double tap across the wrap of the millisecond counter
    add_poll(COUNT_ONE, 12'd10, 12'd10, 32'hFFFF_FFF0);
    add_poll(8'd0, 12'd0, 12'd0, 32'hFFFF_FFF8);
    add_poll(COUNT_ONE, 12'd10, 12'd10, 32'h0000_0004);
    add_poll(8'd0, 12'd0, 12'd0, 32'h0000_0010);
    // zero threshold in landscape on a wide flat panel: one pixel is a swipe
    add_write(CFG_SWIPE_THRESH, 0);
    add_write(CFG_ROTATION, ROT_LANDSCAPE);
    add_write(CFG_PANEL_WIDTH, 4096);
    add_write(CFG_PANEL_HEIGHT, 1);
    add_poll(COUNT_ONE, 12'd0, 12'd0, 32'd1000);
    add_poll(COUNT_ONE, 12'd0, 12'd1, 32'd1010);
    add_poll(8'd0, 12'd0, 12'd0, 32'd1020);
    // inverted portrait on a one-pixel panel: most negative coordinates
    add_write(CFG_ROTATION, ROT_PORTRAIT_INV);
    add_write(CFG_PANEL_WIDTH, 1);
    add_poll(COUNT_TWO, 12'hFFF, 12'hFFF, 32'd1100);
    add_poll(8'd0, 12'd0, 12'd0, 32'd1200);
    // inverted landscape, zero window: taps at the same stamp still pair
    add_write(CFG_ROTATION, ROT_LANDSCAPE_INV);
    add_write(CFG_SWIPE_THRESH, 4095);
    add_write(CFG_TAP_WINDOW, 0);
    add_poll(COUNT_ONE, 12'd5, 12'hFFF, 32'd2000);
    add_poll(8'd0, 12'd0, 12'd0, 32'd2000);
    add_poll(COUNT_ONE, 12'd5, 12'hFFF, 32'd2000);
    add_poll(8'd0, 12'd0, 12'd0, 32'd2000);
    add_poll(8'd4, 12'd0, 12'd0, 32'd2001);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else send_poll(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].e);
    end

    // Random gestures, a fresh register setting per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_mode = IDLE_NONE;
      case (seg)
        0: write_all(ROT_PORTRAIT, 1, 1, 1, 0);
        1: write_all(ROT_LANDSCAPE_INV, 4096, 4096, 4095, 65535);
        2: write_all(ROT_LANDSCAPE, $urandom_range(1, 4096), $urandom_range(1, 4096),
                     $urandom_range(1, 300), $urandom_range(0, 1000));
        3: write_all(ROT_PORTRAIT_INV, $urandom_range(1, 4096), $urandom_range(1, 4096),
                     $urandom_range(1, 300), $urandom_range(0, 1000));
        default: write_all(2'($urandom), $urandom_range(1, 4096), $urandom_range(1, 4096),
                           $urandom_range(1, 300), $urandom_range(0, 1000));
      endcase
      idle_mode = seg / 2;
      polls_sent = 0;
      while (polls_sent < POLLS_PER_SEGMENT) run_gesture();
    end

    // Drop valid, drain, then give the pipeline a few more cycles
    @(negedge clk);
    poll_valid = 1'b0;
    idle_mode = IDLE_NONE;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_touch_rotate_and_gesture_detect: done, clean");
    end else begin
      $display("tb_touch_rotate_and_gesture_detect: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tgd_pkg.sv
sv/tgd_front.sv
sv/tgd_queue.sv
sv/tgd_back.sv
sv/touch_rotate_and_gesture_detect.sv
test/tb_touch_rotate_and_gesture_detect.sv
